/* rtl/rics_pkg.sv */
package rics_pkg;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_TRAP    = 6'h1a;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV  = 6'h1a;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_SLT  = 6'h2a;

  // trap codes
  localparam logic [3:0] TR_NEWLINE = 4'h0;
  localparam logic [3:0] TR_PRINT   = 4'h1;
  localparam logic [3:0] TR_READ    = 4'h5;
  localparam logic [3:0] TR_HALT    = 4'ha;

  // console events
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_NEWLINE = 3'd1;
  localparam logic [2:0] EV_PRINT   = 3'd2;
  localparam logic [2:0] EV_INPUT   = 3'd3;
  localparam logic [2:0] EV_HALT    = 3'd4;
  localparam logic [2:0] EV_UNIMPL  = 3'd5;

  localparam logic [31:0] DMEM_BASE      = 32'h1000_0000;
  localparam logic [31:0] GP_RESET       = 32'h1000_8000;
  localparam logic [31:0] START_PC_RESET = 32'h0040_0000;

  localparam logic [0:0] REG_START_PC = 1'b0;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [2:0]  console_event;
    logic [31:0] console_value;
    logic        halted;
  } result_t;

endpackage

/* rtl/risc_integer_core_subset_top.sv */
// Subset integer core: one instruction per input word, no delay slots.
// Input stream s_axis: tdata = {console_in, instr}; one word per instruction
// fetched at the previous next_pc (start_pc after reset or a start_pc write).
// Output stream m_axis: one result word per instruction carrying next_pc,
// console event, console value and the halted flag.
// The register file and the data memory are synchronous memories with registered
// read data. A plain instruction goes from accept through S_READ (decode and read),
// S_EXEC (execute and write back) and S_OUT (result). Loads add S_LOAD for the data
// memory read; mult adds S_MUL for the four 16x16 partial products and S_DIVF to
// write hi and lo; div runs a radix-2 restoring divider in S_DIV, 32 steps, then
// the sign fix in S_DIVF.
// A word taken once the core has halted goes straight to S_OUT for its result.
// The next word is taken only once the result
// register is free, so a stalled receiver holds the core after one result.
// After reset a clearing pass writes every data memory word to zero, and
// the reset values into the register file, one entry a cycle, over
// max(DMEM_WORDS, 32) entries, during which no word is accepted. Configuration writes
// through the APB port are taken at any time; start_pc also loads the pc.
module risc_integer_core_subset_top #(
  parameter int DMEM_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // instruction stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] instr, [63:32] console_in
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [31:0] next_pc, [34:32] console_event,
                                      // [66:35] console_value, [67] halted
);
  import rics_pkg::*;

  localparam int AW = (DMEM_WORDS > 32) ? $clog2(DMEM_WORDS) : 5;
  localparam int CLR_WORDS = (DMEM_WORDS > 32) ? DMEM_WORDS : 32;
  localparam logic [AW:0] CLR_LAST = (AW+1)'(CLR_WORDS - 1);
  localparam logic [31:0] SP_RESET = DMEM_BASE + 32'(DMEM_WORDS) * 32'd4;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_LOAD  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DIVF  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;

  // memories
  logic [31:0] rf_a [32];
  logic [31:0] rf_b [32];
  logic [31:0] dmem [DMEM_WORDS];

  logic [31:0] start_pc, pc, hi, lo;
  logic        stop;
  logic [AW-1:0] clr;
  logic [31:0] instr, cin, ra, rb, dmem_q;
  logic        ld_ok;
  logic [4:0]  ld_rt;
  logic        out_valid;
  result_t     res;
  logic        instr_skip;

  // multiply / divide working registers
  logic [1:0]  mstep;
  logic [63:0] macc;
  logic [31:0] ma, mb;
  logic [5:0]  dcnt;
  logic [31:0] dq, dr, dd;
  logic        qneg, rneg;

  // decode
  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd, sh;
  logic [31:0] simm, uimm, pc4, ea, widx;
  assign op   = instr[31:26];
  assign rs   = instr[25:21];
  assign rt   = instr[20:16];
  assign rd   = instr[15:11];
  assign sh   = instr[10:6];
  assign fn   = instr[5:0];
  assign uimm = {16'd0, instr[15:0]};
  assign simm = {{16{instr[15]}}, instr[15:0]};
  assign pc4  = pc + 32'd4;
  assign ea   = ra + simm;
  assign widx = (ea - DMEM_BASE) >> 2;

  logic dm_ok;
  assign dm_ok = widx < 32'(DMEM_WORDS);

  // APB
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_START_PC);
  assign prdata = (paddr == REG_START_PC) ? start_pc : 32'd0;

  assign s_axis_tready = (state == S_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, res.halted, res.console_value, res.console_event,
                          res.next_pc};

  // execute stage results
  logic        wr_en;
  logic [4:0]  wr_a;
  logic [31:0] wr_d, npc, ev_val;
  logic [2:0]  ev;
  logic        set_stop;
  always_comb begin
    wr_en = 1'b0; wr_a = rd; wr_d = 32'd0; npc = pc4;
    ev = EV_NONE; ev_val = 32'd0; set_stop = 1'b0;
    unique case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  begin wr_en = 1'b1; wr_d = ra << sh; end
          FN_SRA:  begin wr_en = 1'b1; wr_d = 32'($signed(ra) >>> sh); end
          FN_JR:   npc = ra;
          FN_MFHI: begin wr_en = 1'b1; wr_d = hi; end
          FN_MFLO: begin wr_en = 1'b1; wr_d = lo; end
          FN_MULT, FN_DIV: ;
          FN_ADDU: begin wr_en = 1'b1; wr_d = ra + rb; end
          FN_SUBU: begin wr_en = 1'b1; wr_d = ra - rb; end
          FN_SLT:  begin wr_en = 1'b1; wr_d = {31'd0, $signed(ra) < $signed(rb)}; end
          default: ev = EV_UNIMPL;
        endcase
      end
      OP_J:   npc = {pc4[31:28], instr[25:0], 2'b00};
      OP_JAL: begin
        npc = {pc4[31:28], instr[25:0], 2'b00};
        wr_en = 1'b1; wr_a = 5'd31; wr_d = pc4;
      end
      OP_BEQ: if (ra == rb) npc = pc4 + (simm << 2);
      OP_BNE: if (ra != rb) npc = pc4 + (simm << 2);
      OP_ADDIU: begin wr_en = 1'b1; wr_a = rt; wr_d = ra + simm; end
      OP_ANDI:  begin wr_en = 1'b1; wr_a = rt; wr_d = ra & uimm; end
      OP_LUI:   begin wr_en = 1'b1; wr_a = rt; wr_d = uimm << 16; end
      OP_TRAP: begin
        case (instr[3:0])
          TR_NEWLINE: ev = EV_NEWLINE;
          TR_PRINT:   begin ev = EV_PRINT; ev_val = ra; end
          TR_READ:    begin ev = EV_INPUT; wr_en = 1'b1; wr_a = rt; wr_d = cin; end
          TR_HALT:    begin ev = EV_HALT; set_stop = 1'b1; end
          default:    begin ev = EV_UNIMPL; set_stop = 1'b1; end
        endcase
      end
      OP_LW, OP_SW: ;
      default: ev = EV_UNIMPL;
    endcase
  end

  // register file port control
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic [4:0]  rf_ra, rf_rb;
  assign rf_ra = rs;
  assign rf_rb = rt;
  always_comb begin
    rf_we = 1'b0; rf_wa = wr_a; rf_wd = wr_d;
    if (state == S_CLEAR && {1'b0, clr} < (AW+1)'(32)) begin
      rf_we = 1'b1; rf_wa = clr[4:0];
      rf_wd = (clr[4:0] == 5'd28) ? GP_RESET :
              (clr[4:0] == 5'd29) ? SP_RESET : 32'd0;
    end else if (state == S_EXEC && wr_en) begin
      rf_we = (wr_a != 5'd0);
    end else if (state == S_LOAD) begin
      rf_we = (ld_rt != 5'd0); rf_wa = ld_rt;
      rf_wd = ld_ok ? dmem_q : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_a[rf_wa] <= rf_wd;
      rf_b[rf_wa] <= rf_wd;
    end
    ra <= rf_a[rf_ra];
    rb <= rf_b[rf_rb];
  end

  // data memory: clear, store or read
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if ({1'b0, clr} < (AW+1)'(DMEM_WORDS)) dmem[clr] <= 32'd0;
    end else if (state == S_EXEC && op == OP_SW && dm_ok) begin
      dmem[widx[AW-1:0]] <= rb;
    end
    dmem_q <= dmem[widx[AW-1:0]];
  end

  // signed operands for the divider
  logic [31:0] abs_a, abs_b;
  assign abs_a = ra[31] ? -ra : ra;
  assign abs_b = rb[31] ? -rb : rb;

  logic [16:0] mpa, mpb;
  logic [33:0] mprod;
  assign mpa = mstep[0] ? {ma[31], ma[31:16]} : {1'b0, ma[15:0]};
  assign mpb = mstep[1] ? {mb[31], mb[31:16]} : {1'b0, mb[15:0]};
  assign mprod = 34'($signed(mpa) * $signed(mpb));

  logic [32:0] dtrial;
  assign dtrial = {dr, dq[31]} - {1'b0, dd};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      start_pc  <= START_PC_RESET;
      pc        <= START_PC_RESET;
      hi        <= 32'd0;
      lo        <= 32'd0;
      stop      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if ({1'b0, clr} == CLR_LAST) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid && !out_valid) begin
          instr <= s_axis_tdata[31:0];
          cin   <= s_axis_tdata[63:32];
          state <= stop ? S_OUT : S_READ;
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          pc <= npc;
          if (set_stop) stop <= 1'b1;
          res.console_event <= ev;
          res.console_value <= ev_val;
          ld_rt <= rt;
          ld_ok <= dm_ok;
          if (op == OP_LW) begin
            state <= S_LOAD;
          end else if (op == OP_SPECIAL && fn == FN_MULT) begin
            ma <= ra; mb <= rb; mstep <= 2'd0; macc <= 64'd0; state <= S_MUL;
          end else if (op == OP_SPECIAL && fn == FN_DIV && rb != 32'd0) begin
            dq <= abs_a; dr <= 32'd0; dd <= abs_b; dcnt <= 6'd0;
            qneg <= ra[31] ^ rb[31]; rneg <= ra[31]; state <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_LOAD: state <= S_OUT;
        S_MUL: begin
          // accumulate one 16x16 partial product per cycle
          macc  <= macc + (64'($signed(mprod)) <<
                           {2'(mstep[0]) + 2'(mstep[1]), 4'd0});
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) state <= S_DIVF;
        end
        S_DIV: begin
          // one restoring step per cycle
          if (!dtrial[32]) begin
            dr <= dtrial[31:0]; dq <= {dq[30:0], 1'b1};
          end else begin
            dr <= {dr[30:0], dq[31]}; dq <= {dq[30:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd31) state <= S_DIVF;
        end
        S_DIVF: begin
          if (op == OP_SPECIAL && fn == FN_MULT) begin
            hi <= macc[63:32]; lo <= macc[31:0];
          end else begin
            lo <= qneg ? -dq : dq;
            hi <= rneg ? -dr : dr;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          res.next_pc <= pc;
          res.halted  <= stop;
          if (stop && instr_skip) begin
            res.console_event <= EV_NONE;
            res.console_value <= 32'd0;
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_wr) begin
        start_pc <= pwdata;
        pc       <= pwdata;
      end
    end
  end

  // instruction arrived with the core already halted
  always_ff @(posedge clk) begin
    if (rst) instr_skip <= 1'b0;
    else if (state == S_IDLE && s_axis_tvalid && !out_valid) instr_skip <= stop;
  end

  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("accepting while a result is pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_axis_tready)
    else $error("accept during clearing pass");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> m_axis_tvalid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst)
    (rf_we && state != S_CLEAR) |-> (rf_wa != 5'd0))
    else $error("write to register zero");

endmodule

/* tb/risc_core_checker.sv */
// Watches the configuration port and both streams, keeps a copy of the core's
// architectural state, predicts one result word per instruction word and
// compares it with what the core returns.
module risc_core_checker
  import rics_pkg::*;
#(
  parameter int DMEM_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  output int          errors,
  output int          pending,
  output int          checked
);

  logic [31:0] start_pc;
  logic [31:0] gpr [32];
  logic [31:0] hi_q;
  logic [31:0] lo_q;
  logic [31:0] pc_q;
  logic        stopped;
  logic [31:0] dmem [DMEM_WORDS];
  result_t     expected_q [$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", checked, what, got, want);
    errors++;
  endtask

  function automatic void write_gpr(input logic [4:0] r, input logic [31:0] v);
    if (r != 5'd0) gpr[r] = v;
  endfunction

  // Execute one instruction on the shadow state and return the result word
  function automatic result_t execute(input logic [31:0] ins, input logic [31:0] cin);
    logic [5:0]         op;
    logic [5:0]         fn;
    logic [4:0]         rs;
    logic [4:0]         rt;
    logic [4:0]         rd;
    logic [4:0]         sh;
    logic [31:0]        simm;
    logic [31:0]        a;
    logic [31:0]        b;
    logic [31:0]        pc4;
    logic [31:0]        npc;
    logic [31:0]        idx;
    logic signed [63:0] prod;
    logic [2:0]         ev;
    logic [31:0]        val;
    result_t            r;
    op = ins[31:26];
    fn = ins[5:0];
    rs = ins[25:21];
    rt = ins[20:16];
    rd = ins[15:11];
    sh = ins[10:6];
    simm = {{16{ins[15]}}, ins[15:0]};
    ev = EV_NONE;
    val = '0;
    if (!stopped) begin
      a = gpr[rs];
      b = gpr[rt];
      pc4 = pc_q + 32'd4;
      npc = pc4;
      idx = (a + simm - DMEM_BASE) >> 2;
      case (op)
        OP_SPECIAL: begin
          case (fn)
            FN_SLL:  write_gpr(rd, a << sh);
            FN_SRA:  write_gpr(rd, $signed(a) >>> sh);
            FN_JR:   npc = a;
            FN_MFHI: write_gpr(rd, hi_q);
            FN_MFLO: write_gpr(rd, lo_q);
            FN_MULT: begin
              prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
              hi_q = prod[63:32];
              lo_q = prod[31:0];
            end
            FN_DIV: begin
              // leave hi and lo alone on a zero divisor
              if (b != '0) begin
                if (a == 32'h8000_0000 && b == 32'hffff_ffff) begin
                  lo_q = 32'h8000_0000;
                  hi_q = '0;
                end else begin
                  lo_q = $signed(a) / $signed(b);
                  hi_q = $signed(a) % $signed(b);
                end
              end
            end
            FN_ADDU: write_gpr(rd, a + b);
            FN_SUBU: write_gpr(rd, a - b);
            FN_SLT:  write_gpr(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
            default: ev = EV_UNIMPL;
          endcase
        end
        OP_J:     npc = {pc4[31:28], ins[25:0], 2'b00};
        OP_JAL: begin
          write_gpr(5'd31, pc4);
          npc = {pc4[31:28], ins[25:0], 2'b00};
        end
        OP_BEQ:   if (a == b) npc = pc4 + (simm << 2);
        OP_BNE:   if (a != b) npc = pc4 + (simm << 2);
        OP_ADDIU: write_gpr(rt, a + simm);
        OP_ANDI:  write_gpr(rt, a & {16'h0, ins[15:0]});
        OP_LUI:   write_gpr(rt, {ins[15:0], 16'h0});
        OP_TRAP: begin
          case (ins[3:0])
            TR_NEWLINE: ev = EV_NEWLINE;
            TR_PRINT: begin
              ev = EV_PRINT;
              val = a;
            end
            TR_READ: begin
              ev = EV_INPUT;
              write_gpr(rt, cin);
            end
            TR_HALT: begin
              ev = EV_HALT;
              stopped = 1'b1;
            end
            default: begin
              ev = EV_UNIMPL;
              stopped = 1'b1;
            end
          endcase
        end
        // words outside the memory read as zero and drop stores
        OP_LW: write_gpr(rt, (idx < DMEM_WORDS) ? dmem[idx] : 32'h0);
        OP_SW: if (idx < DMEM_WORDS) dmem[idx] = b;
        default: ev = EV_UNIMPL;
      endcase
      pc_q = npc;
    end
    r.next_pc = pc_q;
    r.console_event = ev;
    r.console_value = val;
    r.halted = stopped;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      start_pc = START_PC_RESET;
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      gpr[28] = GP_RESET;
      gpr[29] = DMEM_BASE + DMEM_WORDS * 4;
      hi_q = '0;
      lo_q = '0;
      pc_q = START_PC_RESET;
      stopped = 1'b0;
      for (int i = 0; i < DMEM_WORDS; i++) dmem[i] = '0;
      expected_q.delete();
      errors = 0;
      checked = 0;
    end else begin
      // register write also loads the pc
      if (psel && penable && pwrite && pready && paddr == REG_START_PC) begin
        start_pc = pwdata;
        pc_q = pwdata;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(execute(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.next_pc = m_axis_tdata[31:0];
        got.console_event = m_axis_tdata[34:32];
        got.console_value = m_axis_tdata[66:35];
        got.halted = m_axis_tdata[67];
        if (expected_q.size() == 0) begin
          $display("unexpected result word: %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.next_pc != want.next_pc) report("next_pc", got.next_pc, want.next_pc);
          if (got.console_event != want.console_event)
            report("console_event", got.console_event, want.console_event);
          if (got.console_value != want.console_value)
            report("console_value", got.console_value, want.console_value);
          if (got.halted != want.halted) report("halted", got.halted, want.halted);
        end
        checked++;
      end
    end
  end

endmodule

/* tb/risc_integer_core_subset_top_tb.sv */
module risc_integer_core_subset_top_tb;
  import rics_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS = 300;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [31:0] instr, [63:32] console_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // [31:0] next_pc, [34:32] console_event,
                               // [66:35] console_value, [67] halted
  int          errors;
  int          pending;
  int          checked;
  int          sent;
  int          idle_cycles;
  bit          send_calm;
  bit          recv_calm;
  int          stall_left;

  risc_integer_core_subset_top uut (.*);

  risc_core_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Instruction encoders
  function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sh,
                                        input logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_trap(input logic [4:0] rs, input logic [4:0] rt,
                                           input logic [3:0] code);
    return {OP_TRAP, rs, rt, 12'h0, code};
  endfunction

  // Mostly avoid clobbering the gp and sp base pointers
  function automatic logic [4:0] dest_reg();
    logic [4:0] r;
    r = 5'($urandom);
    if ((r == 5'd28 || r == 5'd29) && $urandom_range(0, 9) != 0)
      r = 5'($urandom_range(1, 27));
    return r;
  endfunction

  // Offset that mostly lands in data memory off gp or sp, sometimes anywhere
  function automatic logic [15:0] mem_offset(input logic [4:0] base);
    logic [15:0] off;
    off = (base == 5'd28) ? 16'h8000 : 16'hffc0;
    off = off + 16'($urandom_range(0, 15) * 4);
    if ($urandom_range(0, 4) == 0) off[1:0] = 2'($urandom);
    if ($urandom_range(0, 9) == 0) off = 16'($urandom);
    return off;
  endfunction

  function automatic logic [31:0] random_instr();
    int          k;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [15:0] imm;
    logic [5:0]  alu_fn [7];
    logic [31:0] w;
    alu_fn = '{FN_SLL, FN_SRA, FN_ADDU, FN_SUBU, FN_SLT, FN_MFHI, FN_MFLO};
    k = $urandom_range(0, 99);
    rs = 5'($urandom);
    rt = dest_reg();
    rd = dest_reg();
    imm = 16'($urandom);
    case ($urandom_range(0, 5))
      0: imm = 16'h0000;
      1: imm = 16'hffff;
      2: imm = 16'h8000;
      3: imm = 16'h7fff;
      default: ;
    endcase
    if (k < 10) w = enc_i(OP_LUI, rs, rt, imm);
    else if (k < 22) w = enc_i(OP_ADDIU, rs, rt, imm);
    else if (k < 27) w = enc_i(OP_ANDI, rs, rt, imm);
    else if (k < 37) w = enc_r(rs, 5'($urandom), rd, 5'($urandom),
                               alu_fn[$urandom_range(0, 6)]);
    else if (k < 42) w = enc_r(rs, 5'($urandom), rd, 5'($urandom), FN_MULT);
    else if (k < 47) w = enc_r(rs, ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom),
                               rd, 0, FN_DIV);
    else if (k < 72) begin
      rs = ($urandom_range(0, 9) == 0) ? 5'($urandom) : (($urandom_range(0, 1) != 0) ? 5'd28
                                                                                  : 5'd29);
      w = enc_i((k < 60) ? OP_LW : OP_SW, rs, (k < 60) ? rt : 5'($urandom), mem_offset(rs));
    end
    else if (k < 78) w = enc_i(($urandom_range(0, 1) != 0) ? OP_BEQ : OP_BNE, rs,
                               ($urandom_range(0, 2) == 0) ? rs : 5'($urandom), imm);
    else if (k < 82) w = {($urandom_range(0, 1) != 0) ? OP_J : OP_JAL, 26'($urandom)};
    else if (k < 84) w = enc_r(rs, 0, 0, 0, FN_JR);
    else if (k < 92) begin
      case ($urandom_range(0, 2))
        0: w = enc_trap(rs, rt, TR_NEWLINE);
        1: w = enc_trap(rs, rt, TR_PRINT);
        default: w = enc_trap(rs, rt, TR_READ);
      endcase
    end
    else if (k < 96) w = enc_r(rs, 5'($urandom), rd, 5'($urandom), 6'($urandom));
    else w = $urandom;
    // stray bits around a trap code must not halt the core early
    if (w[31:26] == OP_TRAP && !(w[3:0] inside {TR_NEWLINE, TR_PRINT, TR_READ}))
      w[3:0] = TR_PRINT;
    return w;
  endfunction

  function automatic logic [31:0] random_console();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Hand one word to the core, with an optional gap in front
  task automatic send(input logic [31:0] ins, input logic [31:0] cin);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = 0;
    if (!send_calm) begin
      if (r >= 95) gap = $urandom_range(15, 50);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {cin, ins};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // Drain, then write start_pc through a setup and an access cycle
  task automatic set_start_pc(input logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_START_PC;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Result side back-pressure: mostly ready, short and long stalls
  always @(posedge clk) begin
    int r;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (recv_calm || r < 75) m_axis_tready <= 1'b1;
      else begin
        m_axis_tready <= 1'b0;
        stall_left <= (r >= 96) ? $urandom_range(15, 50) : $urandom_range(0, 3);
      end
    end
  end

  // Watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] directed [$];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation but halt and the corner cases
    directed = '{
      enc_i(OP_LUI, 0, 8, 16'h8000),            // r8 = most negative
      enc_i(OP_ADDIU, 0, 9, 16'hffff),          // r9 = -1
      enc_r(8, 9, 0, 0, FN_DIV),                // divide overflow
      enc_r(0, 0, 10, 0, FN_MFHI),
      enc_r(0, 0, 11, 0, FN_MFLO),
      enc_r(9, 0, 0, 0, FN_DIV),                // divide by zero keeps hi/lo
      enc_r(8, 8, 0, 0, FN_MULT),
      enc_r(0, 0, 12, 0, FN_MFHI),
      enc_r(8, 0, 13, 5'd31, FN_SRA),
      enc_r(9, 0, 14, 5'd31, FN_SLL),
      enc_r(8, 9, 15, 0, FN_SLT),
      enc_r(8, 9, 0, 0, FN_ADDU),               // write to zero dropped
      enc_r(8, 9, 16, 0, FN_SUBU),
      enc_i(OP_ANDI, 9, 17, 16'hffff),
      enc_i(OP_SW, 28, 9, 16'h8000),            // first data word
      enc_i(OP_LW, 29, 18, 16'hfffc),           // last data word, unwritten
      enc_i(OP_LW, 28, 19, 16'h8003),           // low address bits ignored
      enc_i(OP_SW, 29, 9, 16'h0000),            // just past the end, dropped
      enc_i(OP_LW, 29, 20, 16'h0000),
      enc_i(OP_BEQ, 8, 8, 16'h8000),
      enc_i(OP_BNE, 8, 9, 16'h7fff),
      {OP_JAL, 26'h3ff_ffff},
      enc_r(9, 0, 0, 0, FN_JR),
      enc_trap(8, 0, TR_READ),                  // read into zero
      enc_trap(8, 21, TR_READ)
    };
    set_start_pc(32'hffff_fffc);
    foreach (directed[i]) send(directed[i], random_console());
    send(enc_trap(8, 0, TR_PRINT), 0);
    send(enc_trap(0, 0, TR_NEWLINE), 0);
    send({OP_J, 26'h0}, 0);
    send({6'h3f, 26'h0}, 0);                    // unknown opcode
    send(enc_r(0, 0, 0, 0, 6'h3f), 0);          // unknown function

    // Random phases under several start addresses
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_start_pc(32'h0000_0000);
        1: set_start_pc(32'hffff_ffff);
        2: set_start_pc(START_PC_RESET);
        default: set_start_pc($urandom);
      endcase
      send_calm = (ph == 2);
      recv_calm = (ph == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          s_axis_tvalid <= 1'b0;
          while (pending != 0) @(posedge clk);
        end
        send(random_instr(), random_console());
      end
    end

    // Stop the core, then confirm it ignores further words
    send_calm = 1'b0;
    recv_calm = 1'b0;
    send(enc_trap(5'($urandom), 5'($urandom),
                  ($urandom_range(0, 1) != 0) ? TR_HALT : 4'($urandom_range(11, 15))),
         0);
    repeat (6) send(random_instr(), random_console());

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d instruction words and %0d result words over five start addresses,",
             sent, checked);
    $display("with divide, multiply, memory, branch and trap corners and a final halt");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rics_pkg.sv
rtl/risc_integer_core_subset_top.sv
tb/risc_core_checker.sv
tb/risc_integer_core_subset_top_tb.sv
